[hdl/mrg_pkg.sv]
// shared types, codes and helpers of the mouse report generator
// no dependencies; compiled first

package mrg_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_REPORT_ID  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAN_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL   = 2'd2;

  localparam logic [15:0] INTERVAL_RESET = 16'd8;
  localparam logic [16:0] STEP_ROUND     = 17'd126;
  // x / 127 for x below 33654 as (x * STEP_RECIP) >> RECIP_SHIFT
  localparam logic [15:0] STEP_RECIP     = 16'd33027;
  localparam int          RECIP_SHIFT    = 22;
  localparam logic [6:0]  CHUNK_MAX      = 7'd127;

  typedef enum logic [2:0] {
    ACT_MOVE       = 3'd0,
    ACT_SCROLL_V   = 3'd1,
    ACT_SCROLL_H   = 3'd2,
    ACT_BUTTON     = 3'd3,
    ACT_MASK       = 3'd4,
    ACT_PLAN       = 3'd5,
    ACT_TICK       = 3'd6,
    ACT_DISCONNECT = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TOT,
    S_TOT_WAIT,
    S_AXIS,
    S_AXIS_WAIT,
    S_MUL,
    S_LEFT
  } seq_state_t;

  typedef struct packed {
    logic signed [7:0] chunk;
    logic [31:0]       acc;
  } drain_t;

  // take at most +-127 out of a residual accumulator
  function automatic drain_t drain(input logic [31:0] acc);
    drain_t d;
    if ($signed(acc) > 32'sd127) begin
      d.chunk = 8'sd127;
    end else if ($signed(acc) < -32'sd127) begin
      d.chunk = -8'sd127;
    end else begin
      d.chunk = acc[7:0];
    end
    d.acc = acc - {{24{d.chunk[7]}}, d.chunk};
    return d;
  endfunction

  function automatic logic signed [7:0] clamp127(input logic signed [15:0] v);
    logic signed [7:0] r;
    if (v > 16'sd127) begin
      r = 8'sd127;
    end else if (v < -16'sd127) begin
      r = -8'sd127;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

[hdl/mrg_in_if.sv]
// event channel of the mouse report generator
// no dependencies

interface mrg_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        action;
  logic signed [15:0] dx;
  logic signed [15:0] dy;
  logic signed [15:0] scroll_amount;
  logic [7:0]        button_mask;
  logic              pressed;
  logic [31:0]       duration_ms;

  modport source (
    output valid, action, dx, dy, scroll_amount, button_mask, pressed, duration_ms,
    input  ready
  );
  modport sink (
    input  valid, action, dx, dy, scroll_amount, button_mask, pressed, duration_ms,
    output ready
  );
endinterface

[hdl/mrg_out_if.sv]
// report channel of the mouse report generator
// no dependencies

interface mrg_out_if;
  logic              valid;
  logic              ready;
  logic [7:0]        buttons;
  logic signed [7:0] delta_x;
  logic signed [7:0] delta_y;
  logic signed [7:0] wheel;
  logic signed [7:0] pan;
  logic              pan_present;

  modport source (
    output valid, buttons, delta_x, delta_y, wheel, pan, pan_present,
    input  ready
  );
  modport sink (
    input  valid, buttons, delta_x, delta_y, wheel, pan, pan_present,
    output ready
  );
endinterface

[hdl/mrg_div.sv]
// shared restoring divider, one quotient bit per cycle
// uses nothing from the package

module mrg_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic [31:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] den_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  logic        ge;

  always_comb begin
    rem_sh  = {rem_r, quo_r[31]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_sub = rem_sh - {1'b0, den_r};
    rem_nxt = ge ? rem_sub[31:0] : rem_sh[31:0];
    quo_nxt = {quo_r[30:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      den_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[hdl/mouse_report_generator.sv]
// mouse report generator: event handling, tick reporting and move planner
// depends on mrg_pkg, mrg_in_if, mrg_out_if and mrg_div
//
//   channel  direction  handshake      carries
//   in_ch    sink       valid/ready    one pointer event
//   out_ch   source     valid/ready    one mouse report
//   cfg_*    sink       cfg_we only    register index and data
//
// move, scroll, button, mask, tick and disconnect events are handled without leaving S_IDLE
// one pass of the serial divider: start, 32 quotient bits, done
// a planned move: step count by one divider pass, or by reciprocal multiply when
// the duration is zero, then per nonzero axis one pass, followed in chunk mode by
// S_MUL and S_LEFT; a zero axis is set directly in S_AXIS
// in_ch.ready is low while the planner runs and while a report waits unread
// reset is synchronous on rst_n and clears event, plan and config state only

module mouse_report_generator (
  input  logic                            clk,
  input  logic                            rst_n,
  mrg_in_if.sink                          in_ch,
  mrg_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [mrg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mrg_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mrg_pkg::*;

  seq_state_t state_r, state_nxt;

  logic [7:0]  report_id_r;
  logic        pan_en_r;
  logic [15:0] interval_r;

  logic [7:0]        buttons_r, buttons_nxt;
  logic signed [7:0] pend_x_r, pend_x_nxt;
  logic signed [7:0] pend_y_r, pend_y_nxt;
  logic [31:0]       scroll_r, scroll_nxt;
  logic [31:0]       panres_r, panres_nxt;
  logic              last_act_r, last_act_nxt;
  logic [31:0]       total_r, total_nxt;
  logic [31:0]       done_steps_r, done_steps_nxt;
  logic signed [7:0] step_r [2];
  logic signed [7:0] step_nxt [2];
  logic signed [7:0] last_r [2];
  logic signed [7:0] last_nxt [2];
  logic [31:0]       spacing_r [2];
  logic [31:0]       spacing_nxt [2];
  logic [31:0]       phase_r [2];
  logic [31:0]       phase_nxt [2];

  // planner work registers
  logic [15:0] abs_r [2];
  logic [15:0] abs_nxt [2];
  logic        neg_r [2];
  logic        neg_nxt [2];
  logic [31:0] dur_r, dur_nxt;
  logic        axis_r, axis_nxt;
  logic        chunk_mode_r, chunk_mode_nxt;
  logic [6:0]  chunk_r, chunk_nxt;
  logic [22:0] prod_r, prod_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        o_buttons_r, o_buttons_nxt;
  logic signed [7:0] o_dx_r, o_dx_nxt;
  logic signed [7:0] o_dy_r, o_dy_nxt;
  logic signed [7:0] o_wheel_r, o_wheel_nxt;
  logic signed [7:0] o_pan_r, o_pan_nxt;
  logic              o_pan_pres_r, o_pan_pres_nxt;

  logic        div_start;
  logic [31:0] div_dividend;
  logic [31:0] div_divisor;
  logic        div_done;
  logic [31:0] div_q;

  logic        in_acc;
  action_t     act;
  logic [15:0] ax_in, ay_in, amax;
  logic [16:0] round_sum;
  logic [32:0] recip_prod;
  logic [31:0] fast_total;
  logic [15:0] cur_abs;
  logic [31:0] cur_abs32;
  logic [15:0] interval_eff;
  logic        plan_act, last_step;
  logic        hit [2];
  logic signed [7:0] plan_pick [2];
  logic signed [7:0] rx, ry, wheel, pan;
  drain_t      d_scroll, d_pan;
  logic        active;
  logic [22:0] left_full;
  logic [6:0]  left_c;
  logic [15:0] total_m1;
  logic [7:0]  chunk_s;

  mrg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_ch.ready = rst_n && (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign act         = action_t'(in_ch.action);

  always_comb begin
    ax_in        = in_ch.dx[15] ? 16'(-in_ch.dx) : in_ch.dx;
    ay_in        = in_ch.dy[15] ? 16'(-in_ch.dy) : in_ch.dy;
    amax         = (abs_r[0] > abs_r[1]) ? abs_r[0] : abs_r[1];
    // fastest plan: ceil(max|d| / 127) without a divider pass
    round_sum    = {1'b0, amax} + STEP_ROUND;
    recip_prod   = {16'd0, round_sum} * {17'd0, STEP_RECIP};
    fast_total   = {21'd0, recip_prod[32:RECIP_SHIFT]};
    cur_abs      = abs_r[axis_r];
    cur_abs32    = {16'd0, cur_abs};
    interval_eff = (interval_r == 16'd0) ? 16'd1 : interval_r;
    total_m1     = 16'(total_r - 32'd1);
    left_full    = {7'd0, cur_abs} - prod_r;
    left_c       = (left_full > 23'd127) ? CHUNK_MAX : left_full[6:0];
    chunk_s      = neg_r[axis_r] ? 8'(8'd0 - {1'b0, chunk_r}) : {1'b0, chunk_r};
  end

  // tick path: plan step pick and residual drains
  always_comb begin
    plan_act  = done_steps_r < total_r;
    last_step = done_steps_r == (total_r - 32'd1);
    for (int k = 0; k < 2; k++) begin
      hit[k]       = (phase_r[k] + 32'd1) == spacing_r[k];
      plan_pick[k] = last_step ? last_r[k] : (hit[k] ? step_r[k] : 8'sd0);
    end
    rx       = plan_act ? plan_pick[0] : pend_x_r;
    ry       = plan_act ? plan_pick[1] : pend_y_r;
    d_scroll = drain(scroll_r);
    d_pan    = drain(panres_r);
    wheel    = d_scroll.chunk;
    pan      = pan_en_r ? d_pan.chunk : 8'sd0;
    active   = (buttons_r != 8'd0) || (rx != 8'sd0) || (ry != 8'sd0) ||
               (wheel != 8'sd0) || (pan != 8'sd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    buttons_nxt    = buttons_r;
    pend_x_nxt     = pend_x_r;
    pend_y_nxt     = pend_y_r;
    scroll_nxt     = scroll_r;
    panres_nxt     = panres_r;
    last_act_nxt   = last_act_r;
    total_nxt      = total_r;
    done_steps_nxt = done_steps_r;
    for (int k = 0; k < 2; k++) begin
      step_nxt[k]    = step_r[k];
      last_nxt[k]    = last_r[k];
      spacing_nxt[k] = spacing_r[k];
      phase_nxt[k]   = phase_r[k];
      abs_nxt[k]     = abs_r[k];
      neg_nxt[k]     = neg_r[k];
    end
    dur_nxt        = dur_r;
    axis_nxt       = axis_r;
    chunk_mode_nxt = chunk_mode_r;
    chunk_nxt      = chunk_r;
    prod_nxt       = prod_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    o_buttons_nxt  = o_buttons_r;
    o_dx_nxt       = o_dx_r;
    o_dy_nxt       = o_dy_r;
    o_wheel_nxt    = o_wheel_r;
    o_pan_nxt      = o_pan_r;
    o_pan_pres_nxt = o_pan_pres_r;
    div_start      = 1'b0;
    div_dividend   = dur_r;
    div_divisor    = {16'd0, interval_eff};

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (act)
            ACT_MOVE: begin
              pend_x_nxt = clamp127(in_ch.dx);
              pend_y_nxt = clamp127(in_ch.dy);
            end
            ACT_SCROLL_V: begin
              scroll_nxt = scroll_r + {{16{in_ch.scroll_amount[15]}}, in_ch.scroll_amount};
            end
            ACT_SCROLL_H: begin
              if (pan_en_r) begin
                panres_nxt = panres_r +
                             {{16{in_ch.scroll_amount[15]}}, in_ch.scroll_amount};
              end
            end
            ACT_BUTTON: begin
              buttons_nxt = in_ch.pressed ? (buttons_r | in_ch.button_mask)
                                          : (buttons_r & ~in_ch.button_mask);
            end
            ACT_MASK: begin
              buttons_nxt = in_ch.button_mask;
            end
            ACT_PLAN: begin
              // a zero move leaves any running plan alone
              if (in_ch.dx != 16'sd0 || in_ch.dy != 16'sd0) begin
                abs_nxt[0] = ax_in;
                abs_nxt[1] = ay_in;
                neg_nxt[0] = in_ch.dx[15];
                neg_nxt[1] = in_ch.dy[15];
                dur_nxt    = in_ch.duration_ms;
                state_nxt  = S_TOT;
              end
            end
            ACT_TICK: begin
              if (report_id_r != 8'd0) begin
                if (plan_act) begin
                  done_steps_nxt = done_steps_r + 32'd1;
                  for (int k = 0; k < 2; k++) begin
                    phase_nxt[k] = hit[k] ? 32'd0 : phase_r[k] + 32'd1;
                  end
                end
                scroll_nxt = d_scroll.acc;
                if (pan_en_r) begin
                  panres_nxt = d_pan.acc;
                end
                pend_x_nxt = 8'sd0;
                pend_y_nxt = 8'sd0;
                if (active || last_act_r) begin
                  last_act_nxt   = active;
                  out_valid_nxt  = 1'b1;
                  o_buttons_nxt  = buttons_r;
                  o_dx_nxt       = rx;
                  o_dy_nxt       = ry;
                  o_wheel_nxt    = wheel;
                  o_pan_nxt      = pan;
                  o_pan_pres_nxt = pan_en_r;
                end
              end
            end
            ACT_DISCONNECT: begin
              buttons_nxt    = '0;
              pend_x_nxt     = '0;
              pend_y_nxt     = '0;
              scroll_nxt     = '0;
              panres_nxt     = '0;
              last_act_nxt   = 1'b0;
              total_nxt      = '0;
              done_steps_nxt = '0;
              for (int k = 0; k < 2; k++) begin
                step_nxt[k]    = '0;
                last_nxt[k]    = '0;
                spacing_nxt[k] = 32'd1;
                phase_nxt[k]   = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_TOT: begin
        // step count: ceil(max|d| / 127) when fastest, else duration / interval
        if (dur_r == 32'd0) begin
          total_nxt      = (fast_total == 32'd0) ? 32'd1 : fast_total;
          done_steps_nxt = '0;
          phase_nxt[0]   = '0;
          phase_nxt[1]   = '0;
          axis_nxt       = 1'b0;
          state_nxt      = S_AXIS;
        end else begin
          div_start = 1'b1;
          state_nxt = S_TOT_WAIT;
        end
      end

      S_TOT_WAIT: begin
        if (div_done) begin
          total_nxt      = (div_q == 32'd0) ? 32'd1 : div_q;
          done_steps_nxt = '0;
          phase_nxt[0]   = '0;
          phase_nxt[1]   = '0;
          axis_nxt       = 1'b0;
          state_nxt      = S_AXIS;
        end
      end

      S_AXIS: begin
        if (cur_abs == 16'd0) begin
          step_nxt[axis_r]    = '0;
          last_nxt[axis_r]    = '0;
          spacing_nxt[axis_r] = 32'd1;
          axis_nxt            = 1'b1;
          state_nxt           = axis_r ? S_IDLE : S_AXIS;
        end else begin
          div_start      = 1'b1;
          chunk_mode_nxt = cur_abs32 >= total_r;
          if (cur_abs32 >= total_r) begin
            div_dividend = cur_abs32;
            div_divisor  = total_r;
          end else begin
            div_dividend = total_r;
            div_divisor  = cur_abs32;
          end
          state_nxt = S_AXIS_WAIT;
        end
      end

      S_AXIS_WAIT: begin
        if (div_done) begin
          if (chunk_mode_r) begin
            chunk_nxt = (div_q > 32'd127) ? CHUNK_MAX : div_q[6:0];
            state_nxt = S_MUL;
          end else begin
            // fewer counts than steps: one count every few steps
            spacing_nxt[axis_r] = (div_q == 32'd0) ? 32'd1 : div_q;
            step_nxt[axis_r]    = neg_r[axis_r] ? -8'sd1 : 8'sd1;
            last_nxt[axis_r]    = neg_r[axis_r] ? -8'sd1 : 8'sd1;
            axis_nxt            = 1'b1;
            state_nxt           = axis_r ? S_IDLE : S_AXIS;
          end
        end
      end

      S_MUL: begin
        // step count is at most the move here, so it fits in 16 bits
        prod_nxt  = chunk_r * total_m1;
        state_nxt = S_LEFT;
      end

      S_LEFT: begin
        step_nxt[axis_r]    = chunk_s;
        last_nxt[axis_r]    = neg_r[axis_r] ? 8'(8'd0 - {1'b0, left_c}) : {1'b0, left_c};
        spacing_nxt[axis_r] = 32'd1;
        axis_nxt            = 1'b1;
        state_nxt           = axis_r ? S_IDLE : S_AXIS;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      report_id_r <= '0;
      pan_en_r    <= 1'b0;
      interval_r  <= INTERVAL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_REPORT_ID:  report_id_r <= cfg_data[7:0];
        CFG_PAN_ENABLE: pan_en_r    <= cfg_data[0];
        CFG_INTERVAL:   interval_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buttons_r    <= '0;
      pend_x_r     <= '0;
      pend_y_r     <= '0;
      scroll_r     <= '0;
      panres_r     <= '0;
      last_act_r   <= 1'b0;
      total_r      <= '0;
      done_steps_r <= '0;
      for (int k = 0; k < 2; k++) begin
        step_r[k]    <= '0;
        last_r[k]    <= '0;
        spacing_r[k] <= 32'd1;
        phase_r[k]   <= '0;
      end
      axis_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      buttons_r    <= buttons_nxt;
      pend_x_r     <= pend_x_nxt;
      pend_y_r     <= pend_y_nxt;
      scroll_r     <= scroll_nxt;
      panres_r     <= panres_nxt;
      last_act_r   <= last_act_nxt;
      total_r      <= total_nxt;
      done_steps_r <= done_steps_nxt;
      for (int k = 0; k < 2; k++) begin
        step_r[k]    <= step_nxt[k];
        last_r[k]    <= last_nxt[k];
        spacing_r[k] <= spacing_nxt[k];
        phase_r[k]   <= phase_nxt[k];
      end
      axis_r      <= axis_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 2; k++) begin
      abs_r[k] <= abs_nxt[k];
      neg_r[k] <= neg_nxt[k];
    end
    dur_r        <= dur_nxt;
    chunk_mode_r <= chunk_mode_nxt;
    chunk_r      <= chunk_nxt;
    prod_r       <= prod_nxt;
    o_buttons_r  <= o_buttons_nxt;
    o_dx_r       <= o_dx_nxt;
    o_dy_r       <= o_dy_nxt;
    o_wheel_r    <= o_wheel_nxt;
    o_pan_r      <= o_pan_nxt;
    o_pan_pres_r <= o_pan_pres_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.buttons     = o_buttons_r;
  assign out_ch.delta_x     = o_dx_r;
  assign out_ch.delta_y     = o_dy_r;
  assign out_ch.wheel       = o_wheel_r;
  assign out_ch.pan         = o_pan_r;
  assign out_ch.pan_present = o_pan_pres_r;

endmodule

[hdl/mrg_checker.sv]
// port-level checks for the mouse report generator, bound to the top level
// depends on mrg_pkg and mouse_report_generator

module mrg_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [2:0]        in_action,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [7:0] out_delta_x,
  input logic signed [7:0] out_delta_y,
  input logic signed [7:0] out_wheel,
  input logic signed [7:0] out_pan,
  input logic              out_pan_present
);
  import mrg_pkg::*;

  // a stalled report stays valid and holds its delta_x and wheel
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_delta_x) && $stable(out_wheel))
    else $error("report changed while stalled");

  // a new report only follows an accepted tick
  a_out_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_action == ACT_TICK))
    else $error("report without a tick");

  // no event is taken while a report waits unread
  a_no_take_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("event taken while report stalled");

  // report deltas, wheel and pan stay within +-127
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_delta_x != -8'sd128 && out_delta_y != -8'sd128 &&
                  out_wheel != -8'sd128 && out_pan != -8'sd128)
    else $error("report field out of range");

  // four-byte reports carry no pan
  a_pan_absent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pan_present |-> out_pan == 8'sd0)
    else $error("pan reported while disabled");

endmodule

bind mouse_report_generator mrg_checker u_mrg_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_action       (in_ch.action),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_delta_x     (out_ch.delta_x),
  .out_delta_y     (out_ch.delta_y),
  .out_wheel       (out_ch.wheel),
  .out_pan         (out_ch.pan),
  .out_pan_present (out_ch.pan_present)
);

[tb/mrg_report_checker.sv]
// report checker for the mouse report generator: watches both channels and the
// register port, predicts each report and compares it field by field
// depends on mrg_pkg, mrg_in_if and mrg_out_if

module mrg_report_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  mrg_in_if                              in_ch,
  mrg_out_if                             out_ch,
  input  logic                           cfg_we,
  input  logic [mrg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mrg_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatches,
  output int                             reports_owed
);

  timeunit 1ns;
  timeprecision 1ps;

  import mrg_pkg::*;

  typedef struct packed {
    logic [7:0] buttons;
    logic [7:0] delta_x;
    logic [7:0] delta_y;
    logic [7:0] wheel;
    logic [7:0] pan;
    logic       pan_present;
  } report_t;

  report_t reports_due[$];
  int      fail_cnt = 0;

  // registers
  logic [7:0]  reg_id;
  logic        pan_on;
  logic [15:0] ival;

  // pointer state
  logic [7:0]  btn;
  int          mv_x, mv_y;
  logic [31:0] wheel_acc, pan_acc;
  bit          was_active;
  logic [31:0] steps_total, steps_done;
  int          step_x, step_y, tail_x, tail_y;
  logic [31:0] gap_x, gap_y;

  function automatic int clamp_count(input int v);
    if (v > 127) return 127;
    if (v < -127) return -127;
    return v;
  endfunction

  function automatic int chunk_of(input logic [31:0] acc);
    int v;
    v = $signed(acc);
    return clamp_count(v);
  endfunction

  function automatic int pick_step(input logic [31:0] n, input logic [31:0] gap,
                                   input int step);
    if (gap <= 1 || (n % gap) == 0) return step;
    return 0;
  endfunction

  // per-axis plan: whole chunks per tick, or single counts every gap ticks
  task automatic split_axis(input int d, input logic [31:0] total, output int step,
                            output int tail, output logic [31:0] gap);
    longint mag, tot, chunk, rest;
    mag = (d < 0) ? -longint'(d) : longint'(d);
    tot = longint'(total);
    step = 0;
    tail = 0;
    gap = 1;
    if (d != 0) begin
      if (mag >= tot) begin
        chunk = mag / tot;
        if (chunk > 127) chunk = 127;
        rest = mag - chunk * (tot - 1);
        if (rest > 127) rest = 127;
        step = (d < 0) ? -int'(chunk) : int'(chunk);
        tail = (d < 0) ? -int'(rest) : int'(rest);
      end else begin
        step = (d < 0) ? -1 : 1;
        tail = step;
        gap = total / mag[31:0];
        if (gap == 0) gap = 1;
      end
    end
  endtask

  task automatic clear_motion();
    btn = '0;
    mv_x = 0;
    mv_y = 0;
    wheel_acc = '0;
    pan_acc = '0;
    was_active = 0;
    steps_total = '0;
    steps_done = '0;
    step_x = 0;
    step_y = 0;
    tail_x = 0;
    tail_y = 0;
    gap_x = 1;
    gap_y = 1;
  endtask

  task automatic note_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_cnt++;
  endtask

  task automatic predict_report(input action_t act, input int dx, input int dy,
                                input int amt, input logic [7:0] m, input logic pr,
                                input logic [31:0] dur);
    report_t     rep;
    logic [31:0] iv, total, ax, ay, sx, sy, n;
    int          rx, ry, wh, pn;
    bit          active;
    case (act)
      ACT_MOVE: begin
        mv_x = clamp_count(dx);
        mv_y = clamp_count(dy);
      end
      ACT_SCROLL_V: wheel_acc = wheel_acc + amt;
      ACT_SCROLL_H: begin
        if (pan_on) pan_acc = pan_acc + amt;
      end
      ACT_BUTTON: begin
        if (pr) btn = btn | m;
        else btn = btn & ~m;
      end
      ACT_MASK: btn = m;
      ACT_PLAN: begin
        if (dx != 0 || dy != 0) begin
          iv = (ival == 0) ? 32'd1 : {16'd0, ival};
          if (dur == 0) begin
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            sx = (ax + 126) / 127;
            sy = (ay + 126) / 127;
            total = (sx > sy) ? sx : sy;
          end else begin
            total = dur / iv;
          end
          if (total == 0) total = 1;
          split_axis(dx, total, step_x, tail_x, gap_x);
          split_axis(dy, total, step_y, tail_y, gap_y);
          steps_total = total;
          steps_done = '0;
        end
      end
      ACT_TICK: begin
        if (reg_id != 0) begin
          if (steps_done < steps_total) begin
            n = steps_done + 1;
            if (steps_done == steps_total - 1) begin
              mv_x = tail_x;
              mv_y = tail_y;
            end else begin
              mv_x = pick_step(n, gap_x, step_x);
              mv_y = pick_step(n, gap_y, step_y);
            end
            steps_done = n;
          end
          wh = chunk_of(wheel_acc);
          wheel_acc = wheel_acc - wh;
          pn = 0;
          if (pan_on) begin
            pn = chunk_of(pan_acc);
            pan_acc = pan_acc - pn;
          end
          rx = mv_x;
          ry = mv_y;
          mv_x = 0;
          mv_y = 0;
          active = (btn != 0) || rx != 0 || ry != 0 || wh != 0 || pn != 0;
          // the first idle tick after activity still reports
          if (active || was_active) begin
            was_active = active;
            rep.buttons = btn;
            rep.delta_x = rx[7:0];
            rep.delta_y = ry[7:0];
            rep.wheel = wh[7:0];
            rep.pan = pn[7:0];
            rep.pan_present = pan_on;
            reports_due.push_back(rep);
          end
        end
      end
      default: clear_motion();
    endcase
  endtask

  task automatic check_report();
    report_t want;
    if (reports_due.size() == 0) begin
      note_mismatch("report transaction with none expected");
    end else begin
      want = reports_due.pop_front();
      if (out_ch.buttons !== want.buttons)
        note_mismatch($sformatf("buttons %h, expected %h", out_ch.buttons, want.buttons));
      if (out_ch.delta_x !== want.delta_x)
        note_mismatch($sformatf("delta_x %h, expected %h", out_ch.delta_x, want.delta_x));
      if (out_ch.delta_y !== want.delta_y)
        note_mismatch($sformatf("delta_y %h, expected %h", out_ch.delta_y, want.delta_y));
      if (out_ch.wheel !== want.wheel)
        note_mismatch($sformatf("wheel %h, expected %h", out_ch.wheel, want.wheel));
      if (out_ch.pan !== want.pan)
        note_mismatch($sformatf("pan %h, expected %h", out_ch.pan, want.pan));
      if (out_ch.pan_present !== want.pan_present)
        note_mismatch($sformatf("pan_present %b, expected %b", out_ch.pan_present,
                                want.pan_present));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      reg_id = '0;
      pan_on = 1'b0;
      ival = INTERVAL_RESET;
      clear_motion();
      reports_due.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) check_report();
      if (cfg_we) begin
        case (cfg_index)
          CFG_REPORT_ID:  reg_id = cfg_data[7:0];
          CFG_PAN_ENABLE: pan_on = cfg_data[0];
          CFG_INTERVAL:   ival = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        predict_report(action_t'(in_ch.action), in_ch.dx, in_ch.dy, in_ch.scroll_amount,
                       in_ch.button_mask, in_ch.pressed, in_ch.duration_ms);
    end
    reports_owed <= reports_due.size();
    mismatches <= fail_cnt;
  end

endmodule

[tb/tb_mouse_report_generator.sv]
// top of the mouse report generator testbench: clock, reset, event stimulus,
// report-side stalls, register writes, watchdog and verdict
// depends on mrg_pkg, mrg_in_if, mrg_out_if, mouse_report_generator, mrg_report_checker

module tb_mouse_report_generator;

  timeunit 1ns;
  timeprecision 1ps;

  import mrg_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 160;

  typedef struct {
    action_t            act;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [15:0] amt;
    logic [7:0]         mask;
    logic               pr;
    logic [31:0]        dur;
  } event_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatches;
  int                    reports_owed;

  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  int          hold_requests = 0;
  int          hold_served;
  int          hold_left;
  int          idle_cycles = 0;
  logic [15:0] cur_ival = INTERVAL_RESET;

  mrg_in_if  ev_ch ();
  mrg_out_if rpt_ch ();

  mouse_report_generator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (ev_ch),
    .out_ch    (rpt_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mrg_report_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (ev_ch),
    .out_ch       (rpt_ch),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .reports_owed (reports_owed)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // report side: random stalls, plus long hold-offs on request
  initial begin
    rpt_ch.ready = 1'b0;
    hold_served = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rpt_ch.ready <= 1'b0;
      end else begin
        rpt_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (ev_ch.valid && ev_ch.ready) || (rpt_ch.valid && rpt_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL mouse_report_generator");
        $finish;
      end
    end
  end

  function automatic event_t mk(action_t a, int x = 0, int y = 0, int amt = 0,
                                int m = 0, bit p = 0, longint dur = 0);
    event_t e;
    e.act = a;
    e.dx = 16'(x);
    e.dy = 16'(y);
    e.amt = 16'(amt);
    e.mask = 8'(m);
    e.pr = p;
    e.dur = 32'(dur);
    return e;
  endfunction

  function automatic logic signed [15:0] rand_delta();
    case ($urandom_range(9))
      0, 1:    return 16'sd0;
      2, 3, 4: return 16'(int'($urandom_range(10)) - 5);
      5, 6:    return 16'(int'($urandom_range(600)) - 300);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_duration();
    logic [31:0] iv;
    iv = (cur_ival == 0) ? 32'd1 : {16'd0, cur_ival};
    case ($urandom_range(9))
      0, 1:    return 32'd0;
      8:       return $urandom_range(300);
      9:       return $urandom;
      default: return $urandom_range(24) * iv + $urandom_range(iv - 1);
    endcase
  endfunction

  function automatic event_t rand_event(bit allow_plan);
    event_t e;
    int     r;
    e.dx = 16'($urandom);
    e.dy = 16'($urandom);
    e.amt = 16'($urandom);
    e.mask = 8'($urandom);
    e.pr = 1'($urandom);
    e.dur = $urandom;
    r = $urandom_range(99);
    if (r < 20) begin
      e.act = ACT_MOVE;
      e.dx = rand_delta();
      e.dy = rand_delta();
    end else if (r < 34) begin
      e.act = (r < 28) ? ACT_SCROLL_V : ACT_SCROLL_H;
      if ($urandom_range(1)) e.amt = 16'(int'($urandom_range(400)) - 200);
    end else if (r < 42) begin
      e.act = ACT_BUTTON;
    end else if (r < 47) begin
      e.act = ACT_MASK;
    end else if (r < 57 && allow_plan) begin
      e.act = ACT_PLAN;
      e.dx = rand_delta();
      e.dy = rand_delta();
      e.dur = rand_duration();
    end else if (r < 98) begin
      e.act = ACT_TICK;
    end else begin
      e.act = ACT_DISCONNECT;
    end
    return e;
  endfunction

  task automatic send_event(input event_t e);
    while ($urandom_range(99) < tx_idle_pct) begin
      ev_ch.valid <= 1'b0;
      @(posedge clk);
    end
    ev_ch.valid <= 1'b1;
    ev_ch.action <= e.act;
    ev_ch.dx <= e.dx;
    ev_ch.dy <= e.dy;
    ev_ch.scroll_amount <= e.amt;
    ev_ch.button_mask <= e.mask;
    ev_ch.pressed <= e.pr;
    ev_ch.duration_ms <= e.dur;
    @(posedge clk);
    while (!ev_ch.ready) @(posedge clk);
  endtask

  // called right after an accepting edge; leaves valid low
  task automatic wait_reports_in();
    ev_ch.valid <= 1'b0;
    @(posedge clk);
    while (reports_owed != 0) @(posedge clk);
  endtask

  // a planned move may still be in the divider after the last report
  task automatic settle();
    wait_reports_in();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input int id, input int pan, input int iv);
    settle();
    write_reg(CFG_REPORT_ID, id);
    write_reg(CFG_PAN_ENABLE, pan);
    write_reg(CFG_INTERVAL, iv);
    cur_ival = 16'(iv);
  endtask

  task automatic run_phase(input int n_items, input int idle_pct, input int stall_pct,
                           input bit with_hold, input bit with_pause);
    event_t e;
    int     cnt;
    int     k;
    bit     mid_done;
    tx_idle_pct = idle_pct;
    rx_stall_pct = stall_pct;
    cnt = 0;
    mid_done = 0;
    while (cnt < n_items) begin
      e = rand_event(1'b1);
      send_event(e);
      cnt++;
      // let a planned move play out over a run of ticks
      if (e.act == ACT_PLAN) begin
        k = $urandom_range(1, 26);
        repeat (k) begin
          if ($urandom_range(4) == 0) send_event(rand_event(1'b0));
          else send_event(mk(ACT_TICK, $urandom, $urandom, $urandom, $urandom));
          cnt++;
        end
      end
      if (!mid_done && cnt >= n_items / 2) begin
        mid_done = 1;
        if (with_hold) begin
          tx_idle_pct = 0;
          hold_requests++;
          repeat (30) begin
            send_event(mk(ACT_MOVE, rand_delta(), rand_delta()));
            send_event(mk(ACT_TICK));
          end
          tx_idle_pct = idle_pct;
        end
        if (with_pause) wait_reports_in();
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_REPORT_ID;
    cfg_data = '0;
    ev_ch.valid = 1'b0;
    ev_ch.action = ACT_TICK;
    ev_ch.dx = '0;
    ev_ch.dy = '0;
    ev_ch.scroll_amount = '0;
    ev_ch.button_mask = '0;
    ev_ch.pressed = 1'b0;
    ev_ch.duration_ms = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // unattached: the tick must leave the pending move alone
    send_event(mk(ACT_MOVE, 100, 100));
    send_event(mk(ACT_TICK));
    set_regs(1, 1, 8);
    send_event(mk(ACT_TICK));
    send_event(mk(ACT_MOVE, -32768, 32767));
    send_event(mk(ACT_TICK));
    send_event(mk(ACT_SCROLL_V, 0, 0, 32767));
    send_event(mk(ACT_SCROLL_V, 0, 0, -32768));
    send_event(mk(ACT_SCROLL_H, 0, 0, 32767));
    send_event(mk(ACT_TICK));
    send_event(mk(ACT_BUTTON, 0, 0, 0, 8'h81, 1));
    send_event(mk(ACT_BUTTON, 0, 0, 0, 8'h01, 0));
    send_event(mk(ACT_TICK));
    send_event(mk(ACT_MASK, 0, 0, 0, 8'hff));
    send_event(mk(ACT_MASK, 0, 0, 0, 8'h00));
    send_event(mk(ACT_TICK));
    send_event(mk(ACT_PLAN, 0, 0, 0, 0, 0, 100));
    send_event(mk(ACT_PLAN, 1000, -3, 0, 0, 0, 0));
    send_event(mk(ACT_TICK));
    send_event(mk(ACT_TICK));
    // x shorter than the step count: single units at a spacing; y in chunks
    send_event(mk(ACT_PLAN, 3, -200, 0, 0, 0, 80));
    send_event(mk(ACT_TICK));
    send_event(mk(ACT_TICK));
    send_event(mk(ACT_TICK));
    send_event(mk(ACT_DISCONNECT));
    send_event(mk(ACT_TICK));

    // pan residual survives a disable and drains once enabled again
    send_event(mk(ACT_SCROLL_H, 0, 0, 1000));
    settle();
    write_reg(CFG_PAN_ENABLE, 0);
    send_event(mk(ACT_SCROLL_H, 0, 0, 50));
    send_event(mk(ACT_TICK));
    send_event(mk(ACT_TICK));
    settle();
    write_reg(CFG_PAN_ENABLE, 1);
    send_event(mk(ACT_TICK));

    run_phase(380, 0, 0, 1'b1, 1'b0);
    set_regs(255, 0, 1);
    run_phase(360, 85, 0, 1'b0, 1'b1);
    set_regs(8'h5a, 1, 65535);
    run_phase(360, 0, 85, 1'b0, 1'b1);
    set_regs(7, 1, 0);
    run_phase(360, 16, 16, 1'b1, 1'b0);
    set_regs(0, 1, 8);
    run_phase(40, 0, 0, 1'b0, 1'b0);

    // large residual swings, then a disconnect clears them
    set_regs(128, 0, 65535);
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    send_event(mk(ACT_DISCONNECT));
    send_event(mk(ACT_SCROLL_V, 0, 0, 32767));
    send_event(mk(ACT_SCROLL_V, 0, 0, 32767));
    send_event(mk(ACT_TICK));
    send_event(mk(ACT_TICK));
    send_event(mk(ACT_DISCONNECT));
    send_event(mk(ACT_TICK));

    wait_reports_in();
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS mouse_report_generator");
    end else begin
      $display("FAIL mouse_report_generator");
    end
    $finish;
  end

endmodule
